// ----- sv/hsl_pkg.sv -----
// ----------------------------------------------------------------------------
// hsl_pkg
// Shared types and fixed-point constants for the HSL gain pixel pipeline.
// ----------------------------------------------------------------------------
package hsl_pkg;

	// restoring divider depth: hue dividend k * 60 * 2^16 stays below 2^33
	localparam int DIV_W = 33;

	localparam logic [16:0] ONE_Q16        = 17'd65536;
	localparam logic [24:0] HUE_MAX_Q16    = 25'd23592960; // 360.0 in Q16
	localparam logic [16:0] THIRD_Q16      = 17'd21845;
	localparam logic [16:0] TWO_THIRDS_Q16 = 17'd43690;
	localparam logic [21:0] HUE_K_SCALE    = 22'd3932160;  // 60 * 2^16

	// floor(y / 255) for y < 2^16: (y * LQ_RECIP) >> LQ_SHIFT
	localparam logic [16:0] LQ_RECIP = 17'd65794;
	localparam int          LQ_SHIFT = 24;
	// floor(x / 45) for x < 2^22: (x * HN_RECIP) >> HN_SHIFT
	localparam logic [22:0] HN_RECIP = 23'd5965233;
	localparam int          HN_SHIFT = 28;

	typedef enum logic [1:0] {
		CFG_HUE_GAIN   = 2'd0,
		CFG_SAT_GAIN   = 2'd1,
		CFG_LIGHT_GAIN = 2'd2
	} cfg_idx_t;

	// segment of the hue-to-channel ramp
	typedef enum logic [1:0] {
		SEG_RISE,
		SEG_HIGH,
		SEG_FALL,
		SEG_LOW
	} seg_t;

	// data that rides alongside the dividers
	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        pass;
		logic [16:0] lq;
	} side_t;

endpackage

// ----- sv/hsl_pix_in_if.sv -----
// ----------------------------------------------------------------------------
// hsl_pix_in_if
// Input pixel channel: valid/ready with one RGB item.
// ----------------------------------------------------------------------------
interface hsl_pix_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;

	modport source(output valid, output red_in, output green_in, output blue_in, input ready);
	modport sink(input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

// ----- sv/hsl_pix_out_if.sv -----
// ----------------------------------------------------------------------------
// hsl_pix_out_if
// Output pixel channel: valid/ready with one RGB item.
// ----------------------------------------------------------------------------
interface hsl_pix_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;

	modport source(output valid, output red_out, output green_out, output blue_out,
		input ready);
	modport sink(input valid, input red_out, input green_out, input blue_out, output ready);
endinterface

// ----- sv/hsl_cfg_if.sv -----
// ----------------------------------------------------------------------------
// hsl_cfg_if
// Register write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface hsl_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ----- sv/hsl_div.sv -----
// ----------------------------------------------------------------------------
// hsl_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module hsl_div #(
	parameter int W  = 33,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          en,
	input  logic [W-1:0]  dividend,
	input  logic [DW-1:0] divisor,
	output logic [W-1:0]  quot
);

	logic [DW-1:0] rem_s [W];
	logic [DW-1:0] den_s [W];
	logic [W-1:0]  num_s [W];
	logic [W-1:0]  quo_s [W];

	for (genvar i = 0; i < W; i++) begin : g_stage
		logic [DW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [W-1:0]  num_in;
		logic [W-1:0]  quo_in;
		logic [DW:0]   trial;
		logic          fits;

		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign den_in = divisor;
			assign num_in = dividend;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign den_in = den_s[i-1];
			assign num_in = num_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		assign trial = {rem_in, num_in[W-1-i]};
		assign fits  = (trial >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= fits ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
				den_s[i] <= den_in;
				num_s[i] <= num_in;
				quo_s[i] <= {quo_in[W-2:0], fits};
			end
		end
	end

	assign quot = quo_s[W-1];

endmodule

// ----- sv/hsl_gain_pixel_adjust.sv -----
// ----------------------------------------------------------------------------
// hsl_gain_pixel_adjust
// RGB -> HSL, per-component gain with clamp, HSL -> RGB, one pixel per clock unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in  - valid/ready item of one 8-bit RGB pixel.
//   pix_out - valid/ready item of the adjusted pixel, same order as input.
//   cfg     - register writes (0 hue, 1 saturation, 2 lightness gain, each
//             unsigned Q4.12 with GAIN_FRAC_BITS fraction bits). Always
//             ready; write only while the pipeline is empty.
// Structure: 43 register stages (4 front, 33 divider, 6 back). Throughput: one
//   item per cycle while the output is taken.
//   Depth is set by the 33-stage restoring dividers for hue and saturation.
// Stall: the whole pipe advances on one enable; when the output register
//   holds an item that is not taken, pix_in.ready drops and every stage
//   holds. Bubbles already in the pipe stay in place while stalled.
// Reset: all valid bits clear, gains return to 4096 (unity, pass-through, for GAIN_FRAC_BITS = 12).
// With all three gains at unity the input pixel is forwarded unchanged.
// ----------------------------------------------------------------------------
module hsl_gain_pixel_adjust #(
	parameter int GAIN_FRAC_BITS = 12
) (
	input logic            clk,
	input logic            arst_n,
	hsl_pix_in_if.sink     pix_in,
	hsl_pix_out_if.source  pix_out,
	hsl_cfg_if.sink        cfg
);

	localparam int DW = hsl_pkg::DIV_W;
	localparam logic [16:0] UNITY = 17'd1 << GAIN_FRAC_BITS;

	// ---------------- configuration registers ----------------
	logic [15:0] hue_gain_q;
	logic [15:0] sat_gain_q;
	logic [15:0] light_gain_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_gain_q   <= 16'd4096;
			sat_gain_q   <= 16'd4096;
			light_gain_q <= 16'd4096;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				hsl_pkg::CFG_HUE_GAIN:   hue_gain_q   <= cfg.data;
				hsl_pkg::CFG_SAT_GAIN:   sat_gain_q   <= cfg.data;
				hsl_pkg::CFG_LIGHT_GAIN: light_gain_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	// One enable for every stage; the output register is the last stage.
	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic vld_d [DW];
	logic vld_g1, vld_g2, vld_g3, vld_g4, vld_g5, vld_g6;

	assign adv          = !vld_g6 || pix_out.ready;
	assign pix_in.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			for (int i = 0; i < DW; i++) vld_d[i] <= 1'b0;
			vld_g1 <= 1'b0;
			vld_g2 <= 1'b0;
			vld_g3 <= 1'b0;
			vld_g4 <= 1'b0;
			vld_g5 <= 1'b0;
			vld_g6 <= 1'b0;
		end else if (adv) begin
			vld_s1   <= pix_in.valid;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_s4   <= vld_s3;
			vld_d[0] <= vld_s4;
			for (int i = 1; i < DW; i++) vld_d[i] <= vld_d[i-1];
			vld_g1 <= vld_d[DW-1];
			vld_g2 <= vld_g1;
			vld_g3 <= vld_g2;
			vld_g4 <= vld_g3;
			vld_g5 <= vld_g4;
			vld_g6 <= vld_g5;
		end
	end

	// ---------------- s1: input register, pass-through decision ----------------
	logic [7:0] red_s1, green_s1, blue_s1;
	logic       pass_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			red_s1   <= pix_in.red_in;
			green_s1 <= pix_in.green_in;
			blue_s1  <= pix_in.blue_in;
			pass_s1  <= ({1'b0, hue_gain_q} == UNITY) && ({1'b0, sat_gain_q} == UNITY)
				&& ({1'b0, light_gain_q} == UNITY);
		end
	end

	// ---------------- s2: max / min ----------------
	logic [7:0] mx_c, mn_c;
	logic [7:0] red_s2, green_s2, blue_s2, mx_s2, mn_s2;
	logic       pass_s2;

	always_comb begin
		mx_c = red_s1;
		mn_c = red_s1;
		if (green_s1 > mx_c) mx_c = green_s1;
		if (blue_s1 > mx_c)  mx_c = blue_s1;
		if (green_s1 < mn_c) mn_c = green_s1;
		if (blue_s1 < mn_c)  mn_c = blue_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_s2   <= red_s1;
			green_s2 <= green_s1;
			blue_s2  <= blue_s1;
			mx_s2    <= mx_c;
			mn_s2    <= mn_c;
			pass_s2  <= pass_s1;
		end
	end

	// ---------------- s3: hue sector, saturation divisor, lightness product ----------------
	logic [7:0]  d_c;
	logic [8:0]  sum_c;
	logic [11:0] kraw_c, k6_c, k_c;
	logic [7:0]  sdiv_c;

	logic [7:0]  red_s3, green_s3, blue_s3, d_s3, sdiv_s3;
	logic [10:0] k_s3;
	logic [8:0]  sum_s3;
	logic [32:0] lqy_s3;
	logic        pass_s3;

	always_comb begin
		d_c   = mx_s2 - mn_s2;
		sum_c = {1'b0, mx_s2} + {1'b0, mn_s2};
		k6_c  = {4'b0, d_c} * 12'd6;
		// sector offset follows whichever channel is the minimum
		if (red_s2 == mn_s2)
			kraw_c = {4'b0, d_c} * 12'd3 - {4'b0, green_s2} + {4'b0, blue_s2};
		else if (green_s2 == mn_s2)
			kraw_c = {4'b0, d_c} * 12'd5 - {4'b0, blue_s2} + {4'b0, red_s2};
		else
			kraw_c = {4'b0, d_c} - {4'b0, red_s2} + {4'b0, green_s2};
		k_c    = (kraw_c >= k6_c) ? (kraw_c - k6_c) : kraw_c;
		sdiv_c = (sum_c <= 9'd255) ? sum_c[7:0] : 8'(9'd510 - sum_c);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_s3   <= red_s2;
			green_s3 <= green_s2;
			blue_s3  <= blue_s2;
			d_s3     <= d_c;
			sdiv_s3  <= sdiv_c;
			k_s3     <= k_c[10:0];
			sum_s3   <= sum_c;
			lqy_s3   <= 33'({sum_c, 7'b0}) * 33'(hsl_pkg::LQ_RECIP);
			pass_s3  <= pass_s2;
		end
	end

	// ---------------- s4: divider operands, lightness ----------------
	logic [DW-1:0]       hdnd_s4, sdnd_s4;
	logic [7:0]          hden_s4, sden_s4;
	hsl_pkg::side_t      side_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			hdnd_s4 <= DW'(k_s3) * DW'(hsl_pkg::HUE_K_SCALE);
			sdnd_s4 <= DW'({d_s3, 16'b0});
			// grey pixel gives a zero dividend; keep divisors nonzero
			hden_s4 <= (d_s3 == 8'd0) ? 8'd1 : d_s3;
			sden_s4 <= (sdiv_s3 == 8'd0) ? 8'd1 : sdiv_s3;
			side_s4.red   <= red_s3;
			side_s4.green <= green_s3;
			side_s4.blue  <= blue_s3;
			side_s4.pass  <= pass_s3;
			// L = 128*sum + floor(128*sum / 255)
			side_s4.lq    <= 17'({sum_s3, 7'b0}) + 17'(lqy_s3 >> hsl_pkg::LQ_SHIFT);
		end
	end

	// ---------------- divider section ----------------
	logic [DW-1:0]  hq_quot, sq_quot;
	hsl_pkg::side_t side_d [DW];

	hsl_div #(.W(DW), .DW(8)) u_hue_div (
		.clk      (clk),
		.en       (adv),
		.dividend (hdnd_s4),
		.divisor  (hden_s4),
		.quot     (hq_quot)
	);

	hsl_div #(.W(DW), .DW(8)) u_sat_div (
		.clk      (clk),
		.en       (adv),
		.dividend (sdnd_s4),
		.divisor  (sden_s4),
		.quot     (sq_quot)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_d[0] <= side_s4;
			for (int i = 1; i < DW; i++) side_d[i] <= side_d[i-1];
		end
	end

	// ---------------- g1: gain products ----------------
	logic [40:0]    hp_g1;
	logic [32:0]    sp_g1, lp_g1;
	hsl_pkg::side_t side_g1;

	always_ff @(posedge clk) begin
		if (adv) begin
			hp_g1   <= 41'(hq_quot[24:0]) * 41'(hue_gain_q);
			sp_g1   <= 33'(sq_quot[16:0]) * 33'(sat_gain_q);
			lp_g1   <= 33'(side_d[DW-1].lq) * 33'(light_gain_q);
			side_g1 <= side_d[DW-1];
		end
	end

	// ---------------- g2: clamp, then L*S and H/360 products ----------------
	logic [40:0] hsh_c;
	logic [32:0] ssh_c, lsh_c;
	logic [24:0] hcl_c;
	logic [16:0] scl_c, lcl_c;

	logic [33:0]    lsp_g2;
	logic [44:0]    hnp_g2;
	logic [16:0]    l_g2, s_g2;
	hsl_pkg::side_t side_g2;

	always_comb begin
		hsh_c = hp_g1 >> GAIN_FRAC_BITS;
		ssh_c = sp_g1 >> GAIN_FRAC_BITS;
		lsh_c = lp_g1 >> GAIN_FRAC_BITS;
		hcl_c = (hsh_c > 41'(hsl_pkg::HUE_MAX_Q16)) ? hsl_pkg::HUE_MAX_Q16 : hsh_c[24:0];
		scl_c = (ssh_c > 33'(hsl_pkg::ONE_Q16)) ? hsl_pkg::ONE_Q16 : ssh_c[16:0];
		lcl_c = (lsh_c > 33'(hsl_pkg::ONE_Q16)) ? hsl_pkg::ONE_Q16 : lsh_c[16:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lsp_g2  <= 34'(lcl_c) * 34'(scl_c);
			// H/360 = (H/8)/45
			hnp_g2  <= 45'(hcl_c[24:3]) * 45'(hsl_pkg::HN_RECIP);
			l_g2    <= lcl_c;
			s_g2    <= scl_c;
			side_g2 <= side_g1;
		end
	end

	// ---------------- g3: Q, P, normalized hue ----------------
	logic [16:0]        ls_c, hn_c;
	logic signed [18:0] q_c;

	logic signed [18:0] q_g3, p_g3;
	logic [16:0]        hn_g3;
	hsl_pkg::side_t     side_g3;

	always_comb begin
		ls_c = 17'(lsp_g2 >> 16);
		hn_c = 17'(hnp_g2 >> hsl_pkg::HN_SHIFT);
		if (l_g2 < 17'd32768)
			q_c = $signed({2'b0, l_g2}) + $signed({2'b0, ls_c});
		else
			q_c = $signed({2'b0, l_g2}) + $signed({2'b0, s_g2}) - $signed({2'b0, ls_c});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_g3    <= q_c;
			p_g3    <= $signed({1'b0, l_g2, 1'b0}) - q_c;
			hn_g3   <= hn_c;
			side_g3 <= side_g2;
		end
	end

	// ---------------- g4..g6: per-channel ramp ----------------
	logic signed [18:0] q_g4, p_g4;
	logic [16:0]        diff_g4;
	hsl_pkg::side_t     side_g4, side_g5, side_g6;
	logic [7:0]         out_g6 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			q_g4    <= q_g3;
			p_g4    <= p_g3;
			diff_g4 <= 17'(q_g3 - p_g3);
			side_g4 <= side_g3;
			side_g5 <= side_g4;
			side_g6 <= side_g5;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_ch
		// red leads by a third, blue trails by a third
		localparam logic signed [18:0] OFS = (c == 0) ? 19'sd21845 :
			(c == 1) ? 19'sd0 : -19'sd21845;

		logic signed [18:0] t0, t;
		logic signed [20:0] t6;
		hsl_pkg::seg_t      seg_c;
		logic [15:0]        fac_c;
		logic [32:0]        prod;
		logic signed [18:0] v_c;
		logic [24:0]        scaled;

		hsl_pkg::seg_t      seg_g4;
		logic [15:0]        fac_g4;
		logic [16:0]        v_g5;

		always_comb begin
			t0 = $signed({2'b0, hn_g3}) + OFS;
			if (t0 < 19'sd0)
				t = t0 + 19'sd65536;
			else if (t0 > 19'sd65536)
				t = t0 - 19'sd65536;
			else
				t = t0;
			t6 = 21'(t) * 21'sd6;
			fac_c = '0;
			if (t6 < 21'sd65536) begin
				seg_c = hsl_pkg::SEG_RISE;
				fac_c = t6[15:0];
			end else if (t < 19'sd32768) begin
				seg_c = hsl_pkg::SEG_HIGH;
			end else if (t6 < 21'sd131072 * 21'sd2) begin
				seg_c = hsl_pkg::SEG_FALL;
				fac_c = 16'((21'sd43690 - 21'(t)) * 21'sd6);
			end else begin
				seg_c = hsl_pkg::SEG_LOW;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				seg_g4 <= seg_c;
				fac_g4 <= fac_c;
			end
		end

		always_comb begin
			prod = 33'(diff_g4) * 33'(fac_g4);
			unique case (seg_g4)
				hsl_pkg::SEG_RISE, hsl_pkg::SEG_FALL:
					v_c = p_g4 + $signed({2'b0, prod[32:16]});
				hsl_pkg::SEG_HIGH: v_c = q_g4;
				default:           v_c = p_g4;
			endcase
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				v_g5 <= (v_c < 19'sd0) ? 17'd0 : v_c[16:0];
			end
		end

		assign scaled = 25'(v_g5) * 25'd255;

		always_ff @(posedge clk) begin
			if (adv) begin
				if (side_g5.pass)
					out_g6[c] <= (c == 0) ? side_g5.red : (c == 1) ? side_g5.green : side_g5.blue;
				else
					out_g6[c] <= scaled[23:16];
			end
		end
	end

	assign pix_out.valid     = vld_g6;
	assign pix_out.red_out   = out_g6[0];
	assign pix_out.green_out = out_g6[1];
	assign pix_out.blue_out  = out_g6[2];

	// ---------------- assertions ----------------
	// reciprocal divide by 360 never exceeds one turn
	a_hn_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_g3 |-> (hn_g3 <= hsl_pkg::ONE_Q16))
		else $error("normalized hue out of range");

	// back conversion relies on Q >= P
	a_q_ge_p: assert property (@(posedge clk) disable iff (!arst_n)
		vld_g3 |-> (q_g3 >= p_g3))
		else $error("Q below P");

	// a held output freezes the front of the pipe too
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_g6 && !pix_out.ready) |=> ($stable(vld_s1) && $stable(vld_s4) && $stable(vld_g3)))
		else $error("pipe moved during stall");

endmodule
